// ===== rtl/core/qsu_pkg.sv =====
// shared types, codes and helper functions for the quoted string unescaper
package qsu_pkg;

    localparam int CHAR_W     = 8;
    localparam int KIND_W     = 2;
    localparam int CODE_W     = 16;
    localparam int DIGIT_W    = 3;
    localparam int MAX_RES    = 3;
    localparam int FIFO_DEPTH = 2;

    localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERR   = 2'd2;

    localparam logic [CODE_W-1:0] MAX_ONE_BYTE = 16'h007F;
    localparam logic [CODE_W-1:0] MAX_TWO_BYTE = 16'h07FF;
    localparam logic [CODE_W-1:0] MASK_TWO_HI  = 16'h07C0;
    localparam logic [CODE_W-1:0] MASK_THR_HI  = 16'hF000;
    localparam logic [CODE_W-1:0] MASK_THR_MID = 16'h0FC0;
    localparam logic [CODE_W-1:0] MASK_LOW     = 16'h003F;
    localparam logic [CHAR_W-1:0] LEAD_TWO     = 8'hC0;
    localparam logic [CHAR_W-1:0] LEAD_THREE   = 8'hE0;
    localparam logic [CHAR_W-1:0] CONT_BYTE    = 8'h80;

    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_STR  = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX  = 3'd3,
        PH_OCT  = 3'd4
    } phase_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] data;
    } entry_t;

    // up to three results caused by one input word, entry 0 first
    typedef struct packed {
        logic [1:0]                cnt;
        entry_t [MAX_RES-1:0]      ent;
    } bundle_t;

    typedef struct packed {
        logic    push;
        bundle_t data;
    } q_wr_t;

    typedef struct packed {
        logic    valid;
        bundle_t data;
    } q_rd_t;

    function automatic bundle_t push_res(input bundle_t b, input logic [KIND_W-1:0] k,
                                         input logic [CHAR_W-1:0] d);
        bundle_t r;
        r = b;
        if (r.cnt != 2'd3)
        begin
            r.ent[r.cnt].kind = k;
            r.ent[r.cnt].data = d;
            r.cnt = r.cnt + 2'd1;
        end
        return r;
    endfunction

    function automatic bundle_t put_utf8(input bundle_t b, input logic [CODE_W-1:0] cp);
        bundle_t r;
        r = b;
        if (cp <= MAX_ONE_BYTE)
        begin
            r = push_res(r, KIND_BYTE, cp[CHAR_W-1:0]);
        end
        else if (cp <= MAX_TWO_BYTE)
        begin
            r = push_res(r, KIND_BYTE, LEAD_TWO + CHAR_W'((cp & MASK_TWO_HI) >> 6));
            r = push_res(r, KIND_BYTE, CONT_BYTE + CHAR_W'(cp & MASK_LOW));
        end
        else
        begin
            r = push_res(r, KIND_BYTE, LEAD_THREE + CHAR_W'((cp & MASK_THR_HI) >> 12));
            r = push_res(r, KIND_BYTE, CONT_BYTE + CHAR_W'((cp & MASK_THR_MID) >> 6));
            r = push_res(r, KIND_BYTE, CONT_BYTE + CHAR_W'(cp & MASK_LOW));
        end
        return r;
    endfunction

    // bit 4 set when the character is not a hex digit
    function automatic logic [4:0] hex_val(input logic [CHAR_W-1:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c inside {["0":"9"]})
        begin
            v = {1'b0, 4'(c - "0")};
        end
        else if (c inside {["a":"f"]})
        begin
            v = {1'b0, 4'(c - "a" + 8'd10)};
        end
        else if (c inside {["A":"F"]})
        begin
            v = {1'b0, 4'(c - "A" + 8'd10)};
        end
        return v;
    endfunction

endpackage

// ===== rtl/core/qsu_char_if.sv =====
// input channel: one character or end-of-buffer word per handshake
interface qsu_char_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [qsu_pkg::CHAR_W-1:0]   in_char;

    modport source (output valid, output func, output in_char, input ready);
    modport sink   (input valid, input func, input in_char, output ready);
endinterface

// ===== rtl/core/qsu_result_if.sv =====
// output channel: one decoded byte, close or error word per handshake
interface qsu_result_if;
    logic                         valid;
    logic                         ready;
    logic [qsu_pkg::KIND_W-1:0]   out_kind;
    logic [qsu_pkg::CHAR_W-1:0]   out_byte;
    logic                         last;

    modport source (output valid, output out_kind, output out_byte, output last, input ready);
    modport sink   (input valid, input out_kind, input out_byte, input last, output ready);
endinterface

// ===== rtl/core/qsu_front.sv =====
// front end: parser state, escape decoding and result bundle building
module qsu_front (
    input  logic                  clk,
    input  logic                  rst_n,
    qsu_char_if.sink              chars,
    input  logic                  full,
    output qsu_pkg::q_wr_t        wr
);

    qsu_pkg::phase_t                   phase_reg, phase_next;
    logic                              single_reg, single_next;
    logic [qsu_pkg::DIGIT_W-1:0]       digits_reg, digits_next;
    logic [qsu_pkg::CODE_W-1:0]        acc_reg, acc_next;
    qsu_pkg::bundle_t                  bundle;
    logic                              str_mode;
    logic                              accept;
    logic [qsu_pkg::CHAR_W-1:0]        c;
    logic [qsu_pkg::CHAR_W-1:0]        open_q;
    logic [4:0]                        hv;

    assign chars.ready = !full;
    assign accept      = chars.valid && chars.ready;
    assign c           = chars.in_char;
    assign open_q      = single_reg ? qsu_pkg::CH_SQUOTE : qsu_pkg::CH_DQUOTE;
    assign hv          = qsu_pkg::hex_val(c);

    always_comb
    begin
        phase_next  = phase_reg;
        single_next = single_reg;
        digits_next = digits_reg;
        acc_next    = acc_reg;
        bundle      = '0;
        str_mode    = 1'b0;
        if (chars.func)
        begin
            if (phase_reg == qsu_pkg::PH_STR || phase_reg == qsu_pkg::PH_ESC ||
                phase_reg == qsu_pkg::PH_HEX || phase_reg == qsu_pkg::PH_OCT)
            begin
                if (phase_reg == qsu_pkg::PH_OCT)
                begin
                    bundle = qsu_pkg::put_utf8(bundle, acc_reg);
                end
                bundle = qsu_pkg::push_res(bundle, qsu_pkg::KIND_ERR, '0);
            end
            phase_next  = qsu_pkg::PH_IDLE;
            digits_next = '0;
            acc_next    = '0;
        end
        else
        begin
            case (phase_reg)
                qsu_pkg::PH_STR:
                begin
                    str_mode = 1'b1;
                end
                qsu_pkg::PH_ESC:
                begin
                    phase_next = qsu_pkg::PH_STR;
                    case (c)
                        "x", "u":
                        begin
                            digits_next = (c == "x") ? 3'd2 : 3'd4;
                            acc_next    = '0;
                            phase_next  = qsu_pkg::PH_HEX;
                        end
                        "0", "1", "2", "3", "4", "5", "6", "7":
                        begin
                            acc_next    = {13'd0, c[2:0]};
                            digits_next = 3'd2;
                            phase_next  = qsu_pkg::PH_OCT;
                        end
                        qsu_pkg::CH_DQUOTE, qsu_pkg::CH_SQUOTE:
                        begin
                            if (c != open_q)
                            begin
                                bundle = qsu_pkg::push_res(bundle, qsu_pkg::KIND_BYTE,
                                                           qsu_pkg::CH_BSLASH);
                            end
                            bundle = qsu_pkg::push_res(bundle, qsu_pkg::KIND_BYTE, c);
                        end
                        "/":
                            bundle = qsu_pkg::push_res(bundle, qsu_pkg::KIND_BYTE, "/");
                        qsu_pkg::CH_BSLASH:
                            bundle = qsu_pkg::push_res(bundle, qsu_pkg::KIND_BYTE,
                                                       qsu_pkg::CH_BSLASH);
                        "b":
                            bundle = qsu_pkg::push_res(bundle, qsu_pkg::KIND_BYTE, 8'h08);
                        "f":
                            bundle = qsu_pkg::push_res(bundle, qsu_pkg::KIND_BYTE, 8'h0C);
                        "r":
                            bundle = qsu_pkg::push_res(bundle, qsu_pkg::KIND_BYTE, 8'h0D);
                        "n":
                            bundle = qsu_pkg::push_res(bundle, qsu_pkg::KIND_BYTE, 8'h0A);
                        "t":
                            bundle = qsu_pkg::push_res(bundle, qsu_pkg::KIND_BYTE, 8'h09);
                        "v":
                            bundle = qsu_pkg::push_res(bundle, qsu_pkg::KIND_BYTE, 8'h0B);
                        "a":
                            bundle = qsu_pkg::push_res(bundle, qsu_pkg::KIND_BYTE, 8'h07);
                        default:
                        begin
                            bundle = qsu_pkg::push_res(bundle, qsu_pkg::KIND_BYTE,
                                                       qsu_pkg::CH_BSLASH);
                            bundle = qsu_pkg::push_res(bundle, qsu_pkg::KIND_BYTE, c);
                        end
                    endcase
                end
                qsu_pkg::PH_HEX:
                begin
                    if (hv[4])
                    begin
                        bundle      = qsu_pkg::push_res(bundle, qsu_pkg::KIND_ERR, '0);
                        phase_next  = qsu_pkg::PH_IDLE;
                        digits_next = '0;
                        acc_next    = '0;
                    end
                    else
                    begin
                        acc_next    = {acc_reg[11:0], hv[3:0]};
                        digits_next = digits_reg - 3'd1;
                        if (digits_next == '0)
                        begin
                            bundle     = qsu_pkg::put_utf8(bundle, acc_next);
                            phase_next = qsu_pkg::PH_STR;
                        end
                    end
                end
                qsu_pkg::PH_OCT:
                begin
                    if (c inside {["0":"7"]} && digits_reg != '0)
                    begin
                        acc_next    = {acc_reg[12:0], c[2:0]};
                        digits_next = digits_reg - 3'd1;
                        if (digits_next == '0)
                        begin
                            bundle     = qsu_pkg::put_utf8(bundle, acc_next);
                            phase_next = qsu_pkg::PH_STR;
                        end
                    end
                    else
                    begin
                        // short octal: flush value, then treat char as plain string char
                        bundle      = qsu_pkg::put_utf8(bundle, acc_reg);
                        digits_next = '0;
                        phase_next  = qsu_pkg::PH_STR;
                        str_mode    = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = qsu_pkg::PH_IDLE;
                    if (c == qsu_pkg::CH_DQUOTE || c == qsu_pkg::CH_SQUOTE)
                    begin
                        single_next = (c == qsu_pkg::CH_SQUOTE);
                        phase_next  = qsu_pkg::PH_STR;
                    end
                end
            endcase

            if (str_mode)
            begin
                if (c == open_q)
                begin
                    bundle     = qsu_pkg::push_res(bundle, qsu_pkg::KIND_CLOSE, '0);
                    phase_next = qsu_pkg::PH_IDLE;
                end
                else if (c == qsu_pkg::CH_BSLASH)
                begin
                    phase_next = qsu_pkg::PH_ESC;
                end
                else
                begin
                    bundle = qsu_pkg::push_res(bundle, qsu_pkg::KIND_BYTE, c);
                end
            end
        end
    end

    assign wr.push = accept && (bundle.cnt != 2'd0);
    assign wr.data = bundle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= qsu_pkg::PH_IDLE;
            single_reg <= 1'b0;
            digits_reg <= '0;
            acc_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            single_reg <= single_next;
            digits_reg <= digits_next;
            acc_reg    <= acc_next;
        end
    end

endmodule

// ===== rtl/core/qsu_fifo.sv =====
// short queue of result bundles between front and back end
module qsu_fifo #(
    parameter int DEPTH = qsu_pkg::FIFO_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  qsu_pkg::q_wr_t        wr,
    output logic                  full,
    input  logic                  pop,
    output qsu_pkg::q_rd_t        rd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    qsu_pkg::bundle_t    mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign do_push  = wr.push && !full;
    assign do_pop   = pop && (cnt_reg != '0);
    assign rd.valid = (cnt_reg != '0);
    assign rd.data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/qsu_back.sv =====
// back end: unpacks bundles into single result words through an output register
module qsu_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  qsu_pkg::q_rd_t        rd,
    output logic                  pop,
    qsu_result_if.source          results
);

    qsu_pkg::bundle_t               work_reg;
    logic [1:0]                     idx_reg;
    logic                           busy_reg;
    logic                           out_valid_reg;
    logic [qsu_pkg::KIND_W-1:0]     out_kind_reg;
    logic [qsu_pkg::CHAR_W-1:0]     out_data_reg;
    logic                           out_last_reg;
    logic                           load;
    qsu_pkg::entry_t                sel;
    logic                           sel_last;
    logic [1:0]                     idx_inc;

    assign load    = !out_valid_reg || results.ready;
    assign idx_inc = idx_reg + 2'd1;

    always_comb
    begin
        pop      = 1'b0;
        sel      = rd.data.ent[0];
        sel_last = (rd.data.cnt == 2'd1);
        if (busy_reg)
        begin
            sel      = work_reg.ent[idx_reg];
            sel_last = (idx_inc == work_reg.cnt);
        end
        else if (load && rd.valid)
        begin
            pop = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !busy_reg && rd.valid)
        begin
            work_reg <= rd.data;
        end
        if (load)
        begin
            out_kind_reg <= sel.kind;
            out_data_reg <= sel.data;
            out_last_reg <= sel_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
        end
        else if (load)
        begin
            out_valid_reg <= busy_reg || rd.valid;
            if (busy_reg)
            begin
                idx_reg <= idx_inc;
                if (sel_last)
                begin
                    busy_reg <= 1'b0;
                end
            end
            else if (rd.valid)
            begin
                idx_reg  <= 2'd1;
                busy_reg <= !sel_last;
            end
        end
    end

    assign results.valid    = out_valid_reg;
    assign results.out_kind = out_kind_reg;
    assign results.out_byte = out_data_reg;
    assign results.last     = out_last_reg;

endmodule

// ===== rtl/core/quoted_string_unescape_utf8_unit.sv =====
// top level of the quoted string unescaper with utf-8 output
// usage:
//   chars carries one word per handshake: a character (func 0) or end of buffer
//   (func 1). results carries decoded bytes, string-closed marks and errors,
//   with last set on the final result word caused by each input word.
//   a word is accepted while the bundle queue between front and back has room;
//   the front decodes it in the accept cycle and queues its results as one bundle
//   (words that cause no result queue nothing).
//   with the back idle, a result passes through the queue (written at the accept
//   edge) and then the output register before it shows on results.valid.
//   throughput: one input word per cycle while each word yields at most one
//   result and the receiver takes every result; a word that yields several
//   results (up to three) holds the output until all of them are sent, and the
//   queue depth of FIFO_DEPTH bundles sets how far the front can run ahead of
//   the back.
//   when the receiver stalls, the output register holds its word and the queue
//   fills, after which chars.ready drops until room frees up.
//   reset clears the parser to idle, empties the queue and drops results.valid.
module quoted_string_unescape_utf8_unit #(
    parameter int FIFO_DEPTH = qsu_pkg::FIFO_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    qsu_char_if.sink              chars,
    qsu_result_if.source          results
);

    qsu_pkg::q_wr_t    wr;
    qsu_pkg::q_rd_t    rd;
    logic              full;
    logic              pop;

    qsu_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars),
        .full  (full),
        .wr    (wr)
    );

    qsu_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .full  (full),
        .pop   (pop),
        .rd    (rd)
    );

    qsu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (rd),
        .pop     (pop),
        .results (results)
    );

endmodule
